// File: hdl/light_level_log_score_window_average_macros.svh
// Assertion macros used by the checker file of the light level block.
`ifndef LIGHT_LEVEL_LOG_SCORE_WINDOW_AVERAGE_MACROS_SVH
`define LIGHT_LEVEL_LOG_SCORE_WINDOW_AVERAGE_MACROS_SVH

// Check cons in the same cycle as ante.
`define LLSW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LLSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/llsw_pkg.sv
// Types, constants and the score log constant function of the light level block.
package llsw_pkg;

  localparam int LUX_W       = 21;
  localparam int SCORE_W     = 15;
  localparam int FILL_W      = 6;
  localparam int LOG_IN_W    = 18;
  localparam int LUX_CLAMP   = 160000;
  localparam int LOG_OFFSET  = 16;
  localparam int LOG_N_BASE  = 4;
  localparam int LOG_MSB     = 30;
  localparam int FRAC_BITS   = 24;
  localparam int EXP_W       = 4;
  localparam int LOG_W       = EXP_W + FRAC_BITS;
  localparam int SCORE_FULL  = 25600;
  localparam int NUM_W       = 44;
  localparam int DIV_W       = 28;
  localparam int QUO_W       = 21;
  localparam int STEP_W      = 5;
  localparam int MEAN_STEPS  = LUX_W;
  localparam int SCORE_STEPS = SCORE_W;

  localparam logic REQ_READING = 1'b0;
  localparam logic REQ_CLOSE   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [LUX_W-1:0] lux_q4;
  } in_beat_t;

  typedef struct packed {
    logic [LUX_W-1:0]   period_lux_q4;
    logic [SCORE_W-1:0] period_score_q8;
    logic [SCORE_W-1:0] window_mean_q8;
    logic [FILL_W-1:0]  window_fill;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  rem_init;
    logic [QUO_W-1:0]  low_bits;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  function automatic logic [63:0] lg_q24(input logic [31:0] x);
    logic [63:0] m;
    logic [63:0] acc;
    int          n;
    n = 0;
    for (int i = 0; i < 31; i++) begin
      if ((x >> (i + 1)) != 0) n = i + 1;
    end
    m   = (64'(x) << 30) >> n;
    acc = 64'(n) << FRAC_BITS;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m      = m >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  localparam logic [63:0] LG_BASE    = lg_q24(32'd16);
  localparam logic [63:0] LG_TOP     = lg_q24(32'd160016);
  localparam logic [63:0] SCORE_DEN  = LG_TOP - LG_BASE;
  localparam logic [63:0] SCORE_HALF = SCORE_DEN >> 1;

endpackage

// File: hdl/llsw_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface llsw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/light_level_log_score_window_average.sv
// Light level period averager with log score and score window mean.
//
//  channel  dir  beat fields
//  sample   in   req_type, lux_q4
//  result   out  period_lux_q4, period_score_q8, window_mean_q8, window_fill
//
// Reading beats are taken back to back while idle. A close runs the shared serial
// divider for 21 + 15 + 15 steps (mean, score, window mean) and the log unit for
// 24 squarings; a zero mean skips log and score, an empty period also the mean.
// Reset clears sums, counts, window total, fill and slot; ring contents stay.
// A stalled result holds in the output register; readings are still taken,
// and a later close waits at its end until that register frees.
module light_level_log_score_window_average #(
  parameter int WINDOW_DEPTH = 60,
  parameter int MAX_READINGS = 16
) (
  input logic            clk,
  input logic            rst,
  llsw_stream_if.sink    sample,
  llsw_stream_if.source  result
);
  import llsw_pkg::*;

  localparam int CNT_W  = $clog2(MAX_READINGS + 1);
  localparam int SUM_W  = LUX_W + CNT_W;
  localparam int HELD_W = $clog2(WINDOW_DEPTH + 1);
  localparam int TOT_W  = SCORE_W + HELD_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MEAN   = 10'b0000000010,
    S_LOG_GO = 10'b0000000100,
    S_LOG    = 10'b0000001000,
    S_NUM    = 10'b0000010000,
    S_SCORE  = 10'b0000100000,
    S_PUSH   = 10'b0001000000,
    S_WIN    = 10'b0010000000,
    S_WMEAN  = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [LUX_W-1:0]    mean;
  logic [LOG_IN_W-1:0] vq;
  logic [NUM_W-1:0]    num;
  logic [SCORE_W-1:0]  score;
  logic [SCORE_W-1:0]  wmean;
  logic                out_valid;
  out_beat_t           out_data;

  logic                accept;
  logic                close;
  logic                emit_go;
  logic [LOG_IN_W-1:0] quo_clamped;

  div_req_t            div_req;
  logic                div_done;
  logic [QUO_W-1:0]    div_quo;
  logic                log_start;
  logic                log_done;
  logic [LOG_W-1:0]    log_diff;
  logic                win_push;
  logic                win_done;
  logic [TOT_W-1:0]    win_total;
  logic [HELD_W-1:0]   win_held;

  assign sample.ready   = state == S_IDLE;
  assign accept         = sample.valid && sample.ready;
  assign close          = sample.payload.req_type == REQ_CLOSE;
  assign emit_go        = (state == S_EMIT) && (!out_valid || result.ready);
  assign result.valid   = out_valid;
  assign result.payload = out_data;
  assign log_start      = (state == S_LOG_GO) && (mean != '0);
  assign win_push       = state == S_PUSH;
  assign quo_clamped    = (div_quo > QUO_W'(LUX_CLAMP)) ? LOG_IN_W'(LUX_CLAMP)
                                                        : div_quo[LOG_IN_W-1:0];

  llsw_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  llsw_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .v     (vq),
    .done  (log_done),
    .diff  (log_diff)
  );

  llsw_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .push  (win_push),
    .score (score),
    .done  (win_done),
    .total (win_total),
    .held  (win_held)
  );

  always_comb begin
    div_req = '0;
    case (state)
      S_IDLE: begin
        div_req.start    = accept && close && (count != '0);
        div_req.steps    = STEP_W'(MEAN_STEPS);
        div_req.rem_init = DIV_W'(sum >> LUX_W);
        div_req.low_bits = sum[LUX_W-1:0];
        div_req.divisor  = DIV_W'(count);
      end
      S_NUM: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(SCORE_STEPS);
        div_req.rem_init = DIV_W'(num >> SCORE_STEPS);
        div_req.low_bits = {num[SCORE_STEPS-1:0], {(QUO_W - SCORE_STEPS){1'b0}}};
        div_req.divisor  = SCORE_DEN[DIV_W-1:0];
      end
      S_WIN: begin
        div_req.start    = win_done;
        div_req.steps    = STEP_W'(SCORE_STEPS);
        div_req.rem_init = DIV_W'(win_total >> SCORE_W);
        div_req.low_bits = {win_total[SCORE_W-1:0], {(QUO_W - SCORE_W){1'b0}}};
        div_req.divisor  = DIV_W'(win_held);
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept && close) state_next = (count != '0) ? S_MEAN : S_LOG_GO;
      S_MEAN:   if (div_done) state_next = S_LOG_GO;
      S_LOG_GO: state_next = (mean == '0) ? S_PUSH : S_LOG;
      S_LOG:    if (log_done) state_next = S_NUM;
      S_NUM:    state_next = S_SCORE;
      S_SCORE:  if (div_done) state_next = S_PUSH;
      S_PUSH:   state_next = S_WIN;
      S_WIN:    if (win_done) state_next = S_WMEAN;
      S_WMEAN:  if (div_done) state_next = S_EMIT;
      S_EMIT:   if (emit_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      if (accept) begin
        if (close) begin
          sum   <= '0;
          count <= '0;
        end else if (count < CNT_W'(MAX_READINGS)) begin
          sum   <= sum + SUM_W'(sample.payload.lux_q4);
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && close && (count == '0)) begin
          mean <= '0;
          vq   <= LOG_IN_W'(LOG_OFFSET);
        end
      end
      S_MEAN: begin
        if (div_done) begin
          mean <= div_quo;
          vq   <= quo_clamped + LOG_IN_W'(LOG_OFFSET);
        end
      end
      S_LOG_GO: if (mean == '0) score <= '0;
      S_LOG: begin
        if (log_done) begin
          num <= NUM_W'(log_diff) * NUM_W'(SCORE_FULL) + NUM_W'(SCORE_HALF);
        end
      end
      S_SCORE: begin
        if (div_done) begin
          score <= (div_quo > QUO_W'(SCORE_FULL)) ? SCORE_W'(SCORE_FULL)
                                                   : div_quo[SCORE_W-1:0];
        end
      end
      S_WMEAN: if (div_done) wmean <= div_quo[SCORE_W-1:0];
      S_EMIT: begin
        if (emit_go) begin
          out_data.period_lux_q4   <= mean;
          out_data.period_score_q8 <= score;
          out_data.window_mean_q8  <= wmean;
          out_data.window_fill     <= FILL_W'(win_held);
        end
      end
      default: ;
    endcase
  end
endmodule

// File: hdl/llsw_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module llsw_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  llsw_pkg::div_req_t          req,
  output logic                        done,
  output logic [llsw_pkg::QUO_W-1:0]  quo
);
  import llsw_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [QUO_W-1:0]  low;
  logic [DIV_W-1:0]  divisor;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DIV_W:0]    rem_ext;
  logic [DIV_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_ext = {rem, low[QUO_W-1]};
    rem_sub = rem_ext - {1'b0, divisor};
    ge      = rem_ext >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      low     <= req.low_bits;
      divisor <= req.divisor;
      quo     <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sub[DIV_W-1:0] : rem_ext[DIV_W-1:0];
      low <= low << 1;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end
endmodule

// File: hdl/llsw_log2.sv
// Serial log2 unit: one fraction bit per squaring step.
module llsw_log2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [llsw_pkg::LOG_IN_W-1:0] v,
  output logic                          done,
  output logic [llsw_pkg::LOG_W-1:0]    diff
);
  import llsw_pkg::*;

  logic [4:0]           lead;
  logic [LOG_MSB:0]     m_init;
  logic [LOG_MSB:0]     m;
  logic [2*LOG_MSB+1:0] sq;
  logic [LOG_MSB+1:0]   t;
  logic [EXP_W-1:0]     expo;
  logic [FRAC_BITS-1:0] frac;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;

  always_comb begin
    lead = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (v[i]) lead = 5'(i);
    end
    m_init = (LOG_MSB + 1)'(v) << (5'(LOG_MSB) - lead);
    sq     = m * m;
    t      = sq[2*LOG_MSB+1:LOG_MSB];
  end

  assign diff = {expo, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m    <= m_init;
      expo <= EXP_W'(lead - 5'(LOG_N_BASE));
      frac <= '0;
    end else if (busy) begin
      m    <= t[LOG_MSB+1] ? t[LOG_MSB+1:1] : t[LOG_MSB:0];
      frac <= {frac[FRAC_BITS-2:0], t[LOG_MSB+1]};
    end
  end
endmodule

// File: hdl/llsw_window.sv
// Ring of recent scores with running total and fill count.
module llsw_window #(
  parameter int  DEPTH  = 60,
  localparam int HELD_W = $clog2(DEPTH + 1),
  localparam int TOT_W  = llsw_pkg::SCORE_W + HELD_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [llsw_pkg::SCORE_W-1:0] score,
  output logic                         done,
  output logic [TOT_W-1:0]             total,
  output logic [HELD_W-1:0]            held
);
  import llsw_pkg::*;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SCORE_W-1:0] ring [DEPTH];
  logic [SCORE_W-1:0] rd;
  logic [SCORE_W-1:0] score_q;
  logic [SLOT_W-1:0]  slot;
  logic               pend;
  logic               full;

  assign full = held == HELD_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      rd      <= ring[slot];
      score_q <= score;
    end
    if (pend) ring[slot] <= score_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      slot  <= '0;
      held  <= '0;
      total <= '0;
    end else begin
      pend <= push;
      done <= pend;
      if (pend) begin
        if (full) begin
          total <= total - TOT_W'(rd) + TOT_W'(score_q);
        end else begin
          total <= total + TOT_W'(score_q);
          held  <= held + HELD_W'(1);
        end
        slot <= (slot == SLOT_W'(DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
      end
    end
  end
endmodule

// File: hdl/llsw_checker.sv
// Port-level assertions for the light level block and their bind.
`include "light_level_log_score_window_average_macros.svh"

module llsw_checker (
  input logic                clk,
  input logic                rst,
  input logic                s_valid,
  input logic                s_ready,
  input logic                s_req,
  input logic                r_valid,
  input logic                r_ready,
  input llsw_pkg::out_beat_t r_data
);
  import llsw_pkg::*;

  `LLSW_ASSERT_NEXT(a_result_hold, clk, rst, r_valid && !r_ready, r_valid && $stable(r_data), "result beat changed while stalled")
  `LLSW_ASSERT_NOW(a_score_range, clk, rst, r_valid, (r_data.period_score_q8 <= SCORE_W'(SCORE_FULL)) && (r_data.window_mean_q8 <= SCORE_W'(SCORE_FULL)), "score above full scale")
  `LLSW_ASSERT_NOW(a_dark_score, clk, rst, r_valid && (r_data.period_lux_q4 == '0), r_data.period_score_q8 == '0, "dark period with nonzero score")
  `LLSW_ASSERT_NEXT(a_close_busy, clk, rst, s_valid && s_ready && (s_req == REQ_CLOSE), !s_ready, "sample taken right after close")
endmodule

bind light_level_log_score_window_average llsw_checker u_llsw_checker (
  .clk     (clk),
  .rst     (rst),
  .s_valid (sample.valid),
  .s_ready (sample.ready),
  .s_req   (sample.payload.req_type),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_data  (result.payload)
);

// File: dv/tb_light_level_log_score_window_average.sv
// Testbench for the light level averager: directed table then random periods, checked per beat.
module tb_light_level_log_score_window_average;
  timeunit 1ns;
  timeprecision 1ps;

  import llsw_pkg::*;

  localparam int WINDOW_DEPTH = 60;
  localparam int MAX_READINGS = 16;
  localparam int ITEM_TARGET  = 1650;
  localparam int STALL_MAX    = 16;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int REPORT_MAX   = 10;
  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  typedef struct packed {
    logic             req;
    logic [LUX_W-1:0] lux;
    logic [4:0]       reps;
    logic             typed;
    out_beat_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  llsw_stream_if #(.payload_t(in_beat_t))  sample_if ();
  llsw_stream_if #(.payload_t(out_beat_t)) result_if ();

  light_level_log_score_window_average #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_READINGS(MAX_READINGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_if.sink),
    .result(result_if.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_row_t dir_rows [0:9] = '{
    '{REQ_CLOSE,   21'd0,      5'd1,  1'b1, '{21'd0, 15'd0, 15'd0, 6'd1}},
    '{REQ_READING, LUX_MAX,    5'd1,  1'b0, '0},
    '{REQ_CLOSE,   21'd0,      5'd1,  1'b1, '{LUX_MAX, 15'd25600, 15'd12800, 6'd2}},
    '{REQ_READING, 21'd160000, 5'd1,  1'b0, '0},
    '{REQ_CLOSE,   21'd0,      5'd1,  1'b1, '{21'd160000, 15'd25600, 15'd17066, 6'd3}},
    '{REQ_READING, LUX_MAX,    5'd16, 1'b0, '0},
    '{REQ_READING, 21'd0,      5'd1,  1'b0, '0},
    '{REQ_CLOSE,   LUX_MAX,    5'd1,  1'b1, '{LUX_MAX, 15'd25600, 15'd19200, 6'd4}},
    '{REQ_READING, 21'd1,      5'd1,  1'b0, '0},
    '{REQ_CLOSE,   21'd0,      5'd1,  1'b0, '0}
  };

  // predictor state
  longint unsigned  lux_sum;
  int unsigned      lux_cnt;
  logic [SCORE_W-1:0] score_hist [WINDOW_DEPTH];
  int unsigned      hist_slot;
  int unsigned      hist_fill;
  longint unsigned  hist_total;

  out_beat_t pending_results [$];

  int  fail_count    = 0;
  int  results_seen  = 0;
  int  items_used    = 0;
  int  items_ignored = 0;
  int  periods       = 0;
  int  window_wraps  = 0;
  int  quiet_cycles  = 0;
  bit  no_idle       = 1'b0;

  function automatic logic [63:0] log2_q24(input logic [31:0] x);
    logic [63:0] mant;
    logic [63:0] res;
    int          top;
    top = 0;
    for (int b = 31; b > 0; b--) begin
      if (x[b] && top == 0) top = b;
    end
    mant = (64'(x) << 30) >> top;
    res  = 64'(top) << FRAC_BITS;
    for (int k = FRAC_BITS - 1; k >= 0; k--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant   = mant >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [SCORE_W-1:0] lux_score(input logic [LUX_W-1:0] mean);
    logic [63:0] q;
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] num;
    logic [63:0] s;
    q = (mean > LUX_CLAMP) ? 64'(LUX_CLAMP) : 64'(mean);
    if (q == 0) return '0;
    base = log2_q24(32'd16);
    span = log2_q24(32'(LUX_CLAMP + 16)) - base;
    num  = (log2_q24(32'(q) + 32'd16) - base) * SCORE_FULL;
    s    = (num + span / 2) / span;
    return (s > SCORE_FULL) ? SCORE_FULL[SCORE_W-1:0] : s[SCORE_W-1:0];
  endfunction

  function automatic bit advance_period(input in_beat_t b, output out_beat_t r);
    logic [LUX_W-1:0]   mean;
    logic [SCORE_W-1:0] score;
    r = '0;
    if (b.req_type == REQ_READING) begin
      if (lux_cnt < MAX_READINGS) begin
        lux_sum += b.lux_q4;
        lux_cnt++;
        items_used++;
      end else begin
        items_ignored++;
      end
      return 1'b0;
    end
    items_used++;
    periods++;
    mean    = (lux_cnt != 0) ? LUX_W'(lux_sum / lux_cnt) : '0;
    score   = lux_score(mean);
    lux_sum = 0;
    lux_cnt = 0;
    if (hist_fill >= WINDOW_DEPTH) hist_total -= score_hist[hist_slot];
    else hist_fill++;
    score_hist[hist_slot] = score;
    hist_total += score;
    if (hist_slot == WINDOW_DEPTH - 1) begin
      hist_slot = 0;
      window_wraps++;
    end else begin
      hist_slot++;
    end
    r.period_lux_q4   = mean;
    r.period_score_q8 = score;
    r.window_mean_q8  = SCORE_W'(hist_total / hist_fill);
    r.window_fill     = FILL_W'(hist_fill);
    return 1'b1;
  endfunction

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  function automatic logic [LUX_W-1:0] pick_lux();
    case ($urandom_range(0, 4))
      0: return LUX_W'($urandom);
      1: return LUX_W'($urandom_range(0, 255));
      2: return LUX_W'($urandom_range(140000, 180000));
      3: return LUX_W'(1) << $urandom_range(0, LUX_W - 1);
      default: return LUX_W'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic void note_fail(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("error at result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
  endfunction

  // drive one sample beat; called and returns at a falling edge
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t predicted;
    int        gap;
    gap = draw_idle();
    if (gap > 0) begin
      sample_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_if.valid   = 1'b1;
    sample_if.payload = b;
    do @(posedge clk); while (!sample_if.ready);
    if (advance_period(b, predicted)) pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    sample_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    in_beat_t beat;
    int       n_read;
    lux_sum    = 0;
    lux_cnt    = 0;
    hist_slot  = 0;
    hist_fill  = 0;
    hist_total = 0;
    rst               = 1'b1;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        beat.req_type = dir_rows[r].req;
        beat.lux_q4   = dir_rows[r].lux;
        send_beat(beat, dir_rows[r].typed, dir_rows[r].want);
      end
    end
    hold_until_drained();

    while (items_used + items_ignored < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       n_read = 0;
        1:       n_read = $urandom_range(MAX_READINGS + 1, MAX_READINGS + 8);
        default: n_read = $urandom_range(1, MAX_READINGS);
      endcase
      repeat (n_read) begin
        beat.req_type = REQ_READING;
        beat.lux_q4   = pick_lux();
        send_beat(beat, 1'b0, '0);
      end
      beat.req_type = REQ_CLOSE;
      beat.lux_q4   = LUX_W'($urandom);
      send_beat(beat, 1'b0, '0);
      if (periods % 25 == 0) hold_until_drained();
    end
    no_idle = 1'b0;

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples (%0d dropped past the reading limit) over %0d periods",
             items_used + items_ignored, items_ignored, periods);
    $display("score window of %0d wrapped %0d times; %0d results checked",
             WINDOW_DEPTH, window_wraps, results_seen);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    out_beat_t got;
    out_beat_t want;
    int        stall;
    result_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        result_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready = 1'b1;
      do @(posedge clk); while (!result_if.valid);
      got = result_if.payload;
      results_seen++;
      if (pending_results.size() == 0) begin
        note_fail("result with nothing pending, lux", -1, got.period_lux_q4);
      end else begin
        want = pending_results.pop_front();
        if (got.period_lux_q4 !== want.period_lux_q4)
          note_fail("period_lux_q4", want.period_lux_q4, got.period_lux_q4);
        if (got.period_score_q8 !== want.period_score_q8)
          note_fail("period_score_q8", want.period_score_q8, got.period_score_q8);
        if (got.window_mean_q8 !== want.window_mean_q8)
          note_fail("window_mean_q8", want.window_mean_q8, got.window_mean_q8);
        if (got.window_fill !== want.window_fill)
          note_fail("window_fill", want.window_fill, got.window_fill);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
